>>> hdl/usb_low_speed_transaction_responder_macros.svh
`ifndef USB_LOW_SPEED_TRANSACTION_RESPONDER_MACROS_SVH
`define USB_LOW_SPEED_TRANSACTION_RESPONDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define USBLR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define USBLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/usblr_pkg.sv
`timescale 1ns / 1ps

package usblr_pkg;

  localparam int RX_CAPACITY = 14;
  localparam int ADDR_W      = 7;
  localparam int LEN_W       = 4;
  localparam int USED_W      = 5;

  typedef enum logic [2:0] {
    ACT_PACKET    = 3'd0,
    ACT_ARM       = 3'd1,
    ACT_FREE      = 3'd2,
    ACT_SET_ADDR  = 3'd3,
    ACT_BUS_RESET = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    PID_SETUP = 3'd0,
    PID_OUT   = 3'd1,
    PID_IN    = 3'd2,
    PID_DATA0 = 3'd3,
    PID_DATA1 = 3'd4
  } pid_t;

  typedef enum logic [1:0] {
    STAGE_NONE  = 2'd0,
    STAGE_SETUP = 2'd1,
    STAGE_OUT   = 2'd2
  } stage_t;

  localparam logic [1:0] HS_NONE = 2'd0;
  localparam logic [1:0] HS_ACK  = 2'd1;
  localparam logic [1:0] HS_NAK  = 2'd2;
  localparam logic [1:0] HS_SEND = 2'd3;

  typedef struct packed {
    logic [2:0]        action;
    logic [2:0]        pid_kind;
    logic [7:0]        address_byte;
    logic [3:0]        rx_remaining;
    logic              endpoint;
    logic [ADDR_W-1:0] new_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        handshake;
    logic              tx_endpoint;
    logic              rx_accepted;
    logic              rx_endpoint;
    logic [LEN_W-1:0]  payload_len;
    logic              rx_is_setup;
    logic [ADDR_W-1:0] current_address;
  } res_t;

endpackage

>>> hdl/usblr_engine.sv
`timescale 1ns / 1ps

module usblr_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  usblr_pkg::req_t req,
  output usblr_pkg::res_t res
);
  import usblr_pkg::*;

  logic [ADDR_W-1:0] device_addr, device_addr_next;
  logic [ADDR_W-1:0] pending_addr, pending_addr_next;
  stage_t            token_stage, token_stage_next;
  logic              active_endpoint, active_endpoint_next;
  logic [1:0]        tx_armed, tx_armed_next;
  logic [1:0]        rx_full, rx_full_next;

  logic              match;
  logic              tok_ep;
  logic [USED_W-1:0] used;

  assign match  = req.address_byte[6:0] == device_addr;
  assign tok_ep = req.address_byte[7];
  // bytes used; an out-of-range remaining count counts as nothing used
  assign used   = ({1'b0, req.rx_remaining} <= USED_W'(RX_CAPACITY))
                  ? (USED_W'(RX_CAPACITY) - {1'b0, req.rx_remaining}) : '0;

  always_comb begin
    device_addr_next     = device_addr;
    pending_addr_next    = pending_addr;
    token_stage_next     = token_stage;
    active_endpoint_next = active_endpoint;
    tx_armed_next        = tx_armed;
    rx_full_next         = rx_full;
    res                  = '0;
    unique case (action_t'(req.action))
      ACT_PACKET: begin
        unique case (pid_t'(req.pid_kind))
          PID_SETUP: begin
            if (match) begin
              token_stage_next     = STAGE_SETUP;
              active_endpoint_next = 1'b0;
            end else begin
              token_stage_next = STAGE_NONE;
            end
          end
          PID_OUT: begin
            if (match) begin
              token_stage_next     = STAGE_OUT;
              active_endpoint_next = tok_ep;
            end else begin
              token_stage_next = STAGE_NONE;
            end
          end
          PID_IN: begin
            if (match) begin
              active_endpoint_next = tok_ep;
              if (tx_armed[tok_ep]) begin
                res.handshake         = HS_SEND;
                res.tx_endpoint       = tok_ep;
                tx_armed_next[tok_ep] = 1'b0;
                // first packet sent commits the pending address
                if (pending_addr != '0) begin
                  device_addr_next  = pending_addr;
                  pending_addr_next = '0;
                end
              end else begin
                res.handshake = HS_NAK;
              end
            end
            token_stage_next = STAGE_NONE;
          end
          PID_DATA0, PID_DATA1: begin
            if (token_stage != STAGE_NONE) begin
              if (!rx_full[active_endpoint]) begin
                rx_full_next[active_endpoint] = 1'b1;
                res.handshake   = HS_ACK;
                res.rx_accepted = 1'b1;
                res.rx_endpoint = active_endpoint;
                res.rx_is_setup = token_stage == STAGE_SETUP;
                res.payload_len = (used > USED_W'(3)) ? LEN_W'(used - USED_W'(3)) : '0;
              end
              token_stage_next = STAGE_NONE;
            end
          end
          default: ;
        endcase
      end
      ACT_ARM:      tx_armed_next[req.endpoint] = 1'b1;
      ACT_FREE:     rx_full_next[req.endpoint] = 1'b0;
      ACT_SET_ADDR: pending_addr_next = req.new_address;
      ACT_BUS_RESET: begin
        device_addr_next     = '0;
        pending_addr_next    = '0;
        token_stage_next     = STAGE_NONE;
        active_endpoint_next = 1'b0;
        tx_armed_next        = '0;
        rx_full_next         = '0;
      end
      default: ;
    endcase
    res.current_address = device_addr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_addr     <= '0;
      pending_addr    <= '0;
      token_stage     <= STAGE_NONE;
      active_endpoint <= 1'b0;
      tx_armed        <= '0;
      rx_full         <= '0;
    end else if (fire) begin
      device_addr     <= device_addr_next;
      pending_addr    <= pending_addr_next;
      token_stage     <= token_stage_next;
      active_endpoint <= active_endpoint_next;
      tx_armed        <= tx_armed_next;
      rx_full         <= rx_full_next;
    end
  end

endmodule

>>> hdl/usblr_out_buf.sv
`timescale 1ns / 1ps

module usblr_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  usblr_pkg::res_t push_data,
  output logic            space,
  output logic            out_valid,
  input  logic            out_ready,
  output usblr_pkg::res_t out_data
);
  import usblr_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic load;

  // output slot can take a new entry this cycle
  assign load  = !out_valid || out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> hdl/usb_low_speed_transaction_responder.sv
`timescale 1ns / 1ps
// A result is registered into the output slot, or into the skid entry while
// the output slot stalls. Throughput: one request per cycle while req_ready is
// high; decision logic sits between the request port and a two-entry result
// buffer, so ready drops only when both are full. Reset (rst, synchronous):
// address zero, nothing armed, buffers free, no token in progress, result buffer empty.

`include "usb_low_speed_transaction_responder_macros.svh"

module usb_low_speed_transaction_responder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [2:0]                     action,
  input  logic [2:0]                     pid_kind,
  input  logic [7:0]                     address_byte,
  input  logic [3:0]                     rx_remaining,
  input  logic                           endpoint,
  input  logic [usblr_pkg::ADDR_W-1:0]   new_address,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [1:0]                     handshake,
  output logic                           tx_endpoint,
  output logic                           rx_accepted,
  output logic                           rx_endpoint,
  output logic [usblr_pkg::LEN_W-1:0]    payload_len,
  output logic                           rx_is_setup,
  output logic [usblr_pkg::ADDR_W-1:0]   current_address
);
  import usblr_pkg::*;

  req_t req;
  res_t res_comb;
  res_t res_q;
  logic fire;

  assign req = '{
    action:       action,
    pid_kind:     pid_kind,
    address_byte: address_byte,
    rx_remaining: rx_remaining,
    endpoint:     endpoint,
    new_address:  new_address
  };

  assign fire = req_valid && req_ready;

  usblr_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req),
    .res  (res_comb)
  );

  usblr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (res_comb),
    .space     (req_ready),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_data  (res_q)
  );

  assign handshake       = res_q.handshake;
  assign tx_endpoint     = res_q.tx_endpoint;
  assign rx_accepted     = res_q.rx_accepted;
  assign rx_endpoint     = res_q.rx_endpoint;
  assign payload_len     = res_q.payload_len;
  assign rx_is_setup     = res_q.rx_is_setup;
  assign current_address = res_q.current_address;

  `USBLR_ASSERT_IMPL(a_stall_needs_result, !req_ready, res_valid, "ready low with no result held")
  `USBLR_ASSERT_NEXT(a_fill_blocks, fire && res_valid && !res_ready, !req_ready, "request not held")
  `USBLR_ASSERT_IMPL(a_rx_means_ack, res_valid && rx_accepted, handshake == HS_ACK, "accepted data without ACK")
  `USBLR_ASSERT_IMPL(a_tx_ep_only_send, res_valid && handshake != HS_SEND, !tx_endpoint, "tx endpoint set without send")

endmodule

>>> dv/tb_usb_low_speed_transaction_responder.sv
`timescale 1ns / 1ps

module tb_usb_low_speed_transaction_responder;
  import usblr_pkg::*;

  // codes the block must ignore
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [2:0] PID_OTHER    = 3'd5;
  localparam logic [2:0] PID_SPARE_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 550;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_BEAT} ready_mode_t;

  // Tracks device state and the replies still owed by the block.
  class reply_tracker;
    logic [ADDR_W-1:0] dev_addr;
    logic [ADDR_W-1:0] pend_addr;
    stage_t            stage;
    logic              act_ep;
    logic [1:0]        armed;
    logic [1:0]        rx_busy;
    res_t              replies_due[$];
    int                failures;

    function new();
      failures = 0;
      clear_state();
    endfunction

    function void clear_state();
      dev_addr  = '0;
      pend_addr = '0;
      stage     = STAGE_NONE;
      act_ep    = 1'b0;
      armed     = '0;
      rx_busy   = '0;
    endfunction

    function int outstanding();
      return replies_due.size();
    endfunction

    function res_t predict_reply(req_t r);
      res_t o;
      int   used;
      logic hit;
      logic tok_ep;
      o      = '0;
      hit    = (r.address_byte[6:0] == dev_addr);
      tok_ep = r.address_byte[7];
      case (r.action)
        ACT_PACKET: begin
          case (r.pid_kind)
            PID_SETUP: begin
              if (hit) begin
                stage  = STAGE_SETUP;
                act_ep = 1'b0;
              end else begin
                stage = STAGE_NONE;
              end
            end
            PID_OUT: begin
              if (hit) begin
                stage  = STAGE_OUT;
                act_ep = tok_ep;
              end else begin
                stage = STAGE_NONE;
              end
            end
            PID_IN: begin
              if (hit) begin
                act_ep = tok_ep;
                if (armed[tok_ep]) begin
                  o.handshake   = HS_SEND;
                  o.tx_endpoint = tok_ep;
                  armed[tok_ep] = 1'b0;
                  // address change takes effect on the first sent packet
                  if (pend_addr != '0) begin
                    dev_addr  = pend_addr;
                    pend_addr = '0;
                  end
                end else begin
                  o.handshake = HS_NAK;
                end
              end
              stage = STAGE_NONE;
            end
            PID_DATA0, PID_DATA1: begin
              if (stage != STAGE_NONE) begin
                if (!rx_busy[act_ep]) begin
                  used = (r.rx_remaining <= RX_CAPACITY) ?
                         (RX_CAPACITY - r.rx_remaining) : 0;
                  rx_busy[act_ep] = 1'b1;
                  o.handshake     = HS_ACK;
                  o.rx_accepted   = 1'b1;
                  o.rx_endpoint   = act_ep;
                  o.rx_is_setup   = (stage == STAGE_SETUP);
                  o.payload_len   = (used > 3) ? LEN_W'(used - 3) : '0;
                end
                stage = STAGE_NONE;
              end
            end
            default: ;
          endcase
        end
        ACT_ARM:       armed[r.endpoint] = 1'b1;
        ACT_FREE:      rx_busy[r.endpoint] = 1'b0;
        ACT_SET_ADDR:  pend_addr = r.new_address;
        ACT_BUS_RESET: clear_state();
        default: ;
      endcase
      o.current_address = dev_addr;
      return o;
    endfunction

    function void note_request(req_t r);
      replies_due.push_back(predict_reply(r));
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      failures++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    task check_reply(res_t got);
      res_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("reply with nothing pending (handshake %0d)", got.handshake));
      end else begin
        want = replies_due.pop_front();
        compare_field("handshake", got.handshake, want.handshake);
        compare_field("tx_endpoint", got.tx_endpoint, want.tx_endpoint);
        compare_field("rx_accepted", got.rx_accepted, want.rx_accepted);
        compare_field("rx_endpoint", got.rx_endpoint, want.rx_endpoint);
        compare_field("payload_len", got.payload_len, want.payload_len);
        compare_field("rx_is_setup", got.rx_is_setup, want.rx_is_setup);
        compare_field("current_address", got.current_address, want.current_address);
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic [2:0]        action = '0;
  logic [2:0]        pid_kind = '0;
  logic [7:0]        address_byte = '0;
  logic [3:0]        rx_remaining = '0;
  logic              endpoint = 1'b0;
  logic [ADDR_W-1:0] new_address = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  logic [1:0]        handshake;
  logic              tx_endpoint;
  logic              rx_accepted;
  logic              rx_endpoint;
  logic [LEN_W-1:0]  payload_len;
  logic              rx_is_setup;
  logic [ADDR_W-1:0] current_address;

  reply_tracker sb;
  res_t         seen_reply;
  int           burst_left = 0;
  int           requests_counted = 0;
  ready_mode_t  ready_mode = RDY_ALWAYS;
  int           ready_left = 0;

  usb_low_speed_transaction_responder uut (
    .clk, .rst,
    .req_valid, .req_ready,
    .action, .pid_kind, .address_byte, .rx_remaining, .endpoint, .new_address,
    .res_valid, .res_ready,
    .handshake, .tx_endpoint, .rx_accepted, .rx_endpoint, .payload_len,
    .rx_is_setup, .current_address
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: stall behaviour switches to a new random mode whenever its random run length runs out
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(RDY_ALWAYS, RDY_BEAT));
      ready_left <= $urandom_range(16, 80);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: res_ready <= 1'b1;
      RDY_COIN:   res_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
      default:    res_ready <= (ready_left[1:0] != 2'b00);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      seen_reply.handshake       = handshake;
      seen_reply.tx_endpoint     = tx_endpoint;
      seen_reply.rx_accepted     = rx_accepted;
      seen_reply.rx_endpoint     = rx_endpoint;
      seen_reply.payload_len     = payload_len;
      seen_reply.rx_is_setup     = rx_is_setup;
      seen_reply.current_address = current_address;
      sb.check_reply(seen_reply);
    end
  end

  function automatic req_t mk_req(logic [2:0] act, logic [2:0] pid, logic [7:0] abyte,
                                  logic [3:0] remain, logic ep, logic [ADDR_W-1:0] naddr);
    req_t r;
    r.action       = act;
    r.pid_kind     = pid;
    r.address_byte = abyte;
    r.rx_remaining = remain;
    r.endpoint     = ep;
    r.new_address  = naddr;
    return r;
  endfunction

  function automatic req_t rand_req();
    return mk_req(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 127)));
  endfunction

  // token aimed at the current address, now and then at a random one
  function automatic req_t token(logic [2:0] pid, logic ep);
    req_t r;
    r              = rand_req();
    r.action       = ACT_PACKET;
    r.pid_kind     = pid;
    r.address_byte = {ep, sb.dev_addr};
    if ($urandom_range(0, 9) == 0)
      r.address_byte[6:0] = 7'($urandom_range(0, 127));
    return r;
  endfunction

  function automatic req_t data_pkt();
    req_t r;
    r          = rand_req();
    r.action   = ACT_PACKET;
    r.pid_kind = $urandom_range(0, 1) ? PID_DATA1 : PID_DATA0;
    return r;
  endfunction

  function automatic req_t fw_event(logic [2:0] act, logic ep);
    req_t r;
    r          = rand_req();
    r.action   = act;
    r.endpoint = ep;
    return r;
  endfunction

  task automatic issue(req_t r);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    req_valid    <= 1'b1;
    action       <= r.action;
    pid_kind     <= r.pid_kind;
    address_byte <= r.address_byte;
    rx_remaining <= r.rx_remaining;
    endpoint     <= r.endpoint;
    new_address  <= r.new_address;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
    requests_counted++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_transaction();
    int   pick;
    logic ep;
    req_t r;
    pick = $urandom_range(0, 99);
    ep   = 1'($urandom_range(0, 1));
    if (pick < 30) begin
      issue(token(PID_SETUP, ep));
      issue(data_pkt());
      if ($urandom_range(0, 9) < 7) issue(fw_event(ACT_FREE, 1'b0));
    end else if (pick < 50) begin
      issue(token(PID_OUT, ep));
      issue(data_pkt());
      if ($urandom_range(0, 9) < 7) issue(fw_event(ACT_FREE, ep));
    end else if (pick < 68) begin
      if ($urandom_range(0, 3) == 0) issue(fw_event(ACT_SET_ADDR, ep));
      if ($urandom_range(0, 3) != 0) issue(fw_event(ACT_ARM, ep));
      issue(token(PID_IN, ep));
    end else if (pick < 80) begin
      r        = rand_req();
      r.action = 3'($urandom_range(ACT_ARM, ACT_SET_ADDR));
      issue(r);
    end else if (pick < 83) begin
      issue(fw_event(ACT_BUS_RESET, ep));
    end else begin
      issue(rand_req());
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: corner cases first
    issue(mk_req(ACT_PACKET, PID_IN, 8'h00, 4'd0, 1'b0, 7'd0));     // NAK, nothing armed
    issue(mk_req(ACT_SPARE_LO, PID_SETUP, 8'h00, 4'd0, 1'b1, 7'h7F));
    issue(mk_req(ACT_SPARE_HI, PID_IN, 8'hFF, 4'd15, 1'b1, 7'h7F));
    issue(mk_req(ACT_PACKET, PID_OTHER, 8'h00, 4'd0, 1'b0, 7'd0));
    issue(mk_req(ACT_PACKET, PID_SPARE_HI, 8'h00, 4'd0, 1'b0, 7'd0));
    issue(mk_req(ACT_PACKET, PID_DATA0, 8'h00, 4'd0, 1'b0, 7'd0));  // no token seen
    issue(mk_req(ACT_PACKET, PID_SETUP, 8'h80, 4'd0, 1'b1, 7'd0));  // ep bit ignored
    issue(mk_req(ACT_PACKET, PID_DATA0, 8'h00, 4'd0, 1'b0, 7'd0));
    issue(mk_req(ACT_PACKET, PID_SETUP, 8'h00, 4'd0, 1'b0, 7'd0));
    issue(mk_req(ACT_PACKET, PID_DATA1, 8'h00, 4'd5, 1'b0, 7'd0));  // buffer still full
    issue(mk_req(ACT_FREE, PID_SETUP, 8'h00, 4'd0, 1'b0, 7'd0));
    issue(mk_req(ACT_FREE, PID_SETUP, 8'h00, 4'd0, 1'b0, 7'd0));    // already free
    issue(mk_req(ACT_PACKET, PID_OUT, 8'h80, 4'd0, 1'b0, 7'd0));
    issue(mk_req(ACT_PACKET, PID_DATA1, 8'h80, 4'd15, 1'b0, 7'd0)); // over capacity
    issue(mk_req(ACT_PACKET, PID_OUT, 8'h7F, 4'd0, 1'b0, 7'd0));    // wrong address
    issue(mk_req(ACT_PACKET, PID_DATA0, 8'h00, 4'd0, 1'b0, 7'd0));
    issue(mk_req(ACT_ARM, PID_SETUP, 8'h00, 4'd0, 1'b1, 7'd0));
    issue(mk_req(ACT_ARM, PID_SETUP, 8'h00, 4'd0, 1'b1, 7'd0));     // already armed
    issue(mk_req(ACT_PACKET, PID_IN, 8'h80, 4'd0, 1'b0, 7'd0));     // send, no pending addr
    issue(mk_req(ACT_SET_ADDR, PID_SETUP, 8'h00, 4'd0, 1'b0, 7'h7F));
    issue(mk_req(ACT_ARM, PID_SETUP, 8'h00, 4'd0, 1'b0, 7'd0));
    issue(mk_req(ACT_PACKET, PID_IN, 8'h00, 4'd0, 1'b0, 7'd0));     // commits address
    issue(mk_req(ACT_PACKET, PID_IN, 8'h00, 4'd0, 1'b0, 7'd0));     // old address now
    issue(mk_req(ACT_PACKET, PID_SETUP, 8'hFF, 4'd0, 1'b0, 7'd0));
    issue(mk_req(ACT_PACKET, PID_DATA0, 8'h00, 4'd11, 1'b0, 7'd0)); // three bytes used
    issue(mk_req(ACT_BUS_RESET, PID_SETUP, 8'h00, 4'd0, 1'b0, 7'd0));
    drain();

    requests_counted = 0;
    while (requests_counted < RANDOM_REQUESTS) begin
      run_transaction();
      if ($urandom_range(0, 49) == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.failures == 0)
      $display("usb_low_speed_transaction_responder verification clean");
    else
      $display("usb_low_speed_transaction_responder verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("usb_low_speed_transaction_responder verification failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/usblr_pkg.sv
hdl/usblr_engine.sv
hdl/usblr_out_buf.sv
hdl/usb_low_speed_transaction_responder.sv
dv/tb_usb_low_speed_transaction_responder.sv
